>>> hdl/avcc_to_annexb_nal_scanner_top_assert.svh
// assertion macros for the avcc to annex b nal scanner
`ifndef AVCC_TO_ANNEXB_NAL_SCANNER_TOP_ASSERT_SVH
`define AVCC_TO_ANNEXB_NAL_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define ANS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ANS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ans_pkg.sv
// shared types and constants for the avcc to annex b nal scanner
`default_nettype none

package ans_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FLAGS_W  = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned ACC_W    = 32;   // four length bytes
    localparam int unsigned OUT_TDATA_W = 16;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

    // prefix position codes
    localparam logic [POS_W-1:0] POS_LEN0    = 3'd0;
    localparam logic [POS_W-1:0] POS_LEN3    = 3'd3;
    localparam logic [POS_W-1:0] POS_HEADER  = 3'd4;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd5;

    // codec codes
    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    // nal type codes
    localparam logic [4:0] H264_SPS = 5'd7;
    localparam logic [4:0] H264_PPS = 5'd8;
    localparam logic [4:0] H264_IDR = 5'd5;
    localparam logic [5:0] H265_VPS = 6'd32;
    localparam logic [5:0] H265_SPS = 6'd33;
    localparam logic [5:0] H265_PPS = 6'd34;
    localparam logic [5:0] H265_IRAP_LO = 6'd16;
    localparam logic [5:0] H265_IRAP_HI = 6'd23;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                end_of_buffer;
        logic [FLAGS_W-1:0]  unit_flags;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/ans_nal_core.sv
// framing state, nal header classification and byte conversion
`default_nettype none

module ans_nal_core #(
    parameter int unsigned NAL_LEN_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic                       codec_select,
    input  wire logic [ans_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       last_byte,
    output ans_pkg::result_t                result
);

    localparam logic [ans_pkg::ACC_W:0] LIMIT_W =
        (({{ans_pkg::ACC_W{1'b0}}, 1'b1}) << NAL_LEN_BITS) - {{ans_pkg::ACC_W{1'b0}}, 1'b1};
    localparam logic [ans_pkg::ACC_W-1:0] LEN_LIMIT = LIMIT_W[ans_pkg::ACC_W-1:0];

    logic [ans_pkg::POS_W-1:0]    pos_reg,   pos_next;
    logic [ans_pkg::ACC_W-1:0]    acc_reg,   acc_next;
    logic [NAL_LEN_BITS-1:0]      rem_reg,   rem_next;
    logic [ans_pkg::FLAGS_W-1:0]  flags_reg, flags_next;
    logic [ans_pkg::STATUS_W-1:0] err_reg,   err_next;

    logic [ans_pkg::ACC_W-1:0]    acc_shift;
    logic [NAL_LEN_BITS-1:0]      rem_dec;
    logic [ans_pkg::BYTE_W-1:0]   ob;

    // presence flag for one nal header byte
    function automatic logic [ans_pkg::FLAGS_W-1:0] classify(
        input logic codec, input logic [ans_pkg::BYTE_W-1:0] hdr);
        logic [4:0] t4;
        logic [5:0] t5;
        logic [ans_pkg::FLAGS_W-1:0] f;
        t4 = hdr[4:0];
        t5 = hdr[6:1];
        f  = '0;
        if (codec == ans_pkg::CODEC_H264) begin
            if (t4 == ans_pkg::H264_SPS)      f = 4'b0001;
            else if (t4 == ans_pkg::H264_PPS) f = 4'b0010;
            else if (t4 == ans_pkg::H264_IDR) f = 4'b0100;
        end else begin
            if (t5 == ans_pkg::H265_VPS)      f = 4'b0001;
            else if (t5 == ans_pkg::H265_SPS) f = 4'b0010;
            else if (t5 == ans_pkg::H265_PPS) f = 4'b0100;
            else if (t5 >= ans_pkg::H265_IRAP_LO && t5 <= ans_pkg::H265_IRAP_HI)
                f = 4'b1000;
        end
        return f;
    endfunction

    assign acc_shift = {acc_reg[ans_pkg::ACC_W-ans_pkg::BYTE_W-1:0], data_byte};
    assign rem_dec   = rem_reg - {{(NAL_LEN_BITS-1){1'b0}}, 1'b1};

    // per-byte state update and result
    always_comb begin
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        flags_next = flags_reg;
        err_next   = err_reg;
        ob         = data_byte;
        if (err_reg == ans_pkg::ST_OK) begin
            if (pos_reg < ans_pkg::POS_HEADER) begin
                // length prefix byte becomes a start code byte
                ob       = (pos_reg == ans_pkg::POS_LEN3) ? 8'd1 : 8'd0;
                acc_next = acc_shift;
                pos_next = pos_reg + 3'd1;
                if (pos_reg == ans_pkg::POS_LEN3) begin
                    if (acc_shift == '0)
                        err_next = ans_pkg::ST_ZERO_LEN;
                    else if (codec_select == ans_pkg::CODEC_H265 && acc_shift < 32'd2)
                        err_next = ans_pkg::ST_SHORT;
                    else if (acc_shift > LEN_LIMIT)
                        err_next = ans_pkg::ST_TRUNC;
                    else
                        rem_next = acc_shift[NAL_LEN_BITS-1:0];
                end
            end else begin
                // header or payload byte
                if (pos_reg == ans_pkg::POS_HEADER) begin
                    flags_next = flags_reg | classify(codec_select, data_byte);
                    pos_next   = ans_pkg::POS_PAYLOAD;
                end
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    pos_next = ans_pkg::POS_LEN0;
                    acc_next = '0;
                end
            end
            if (last_byte && err_next == ans_pkg::ST_OK && pos_next != ans_pkg::POS_LEN0)
                err_next = ans_pkg::ST_TRUNC;
        end

        result.out_byte      = ob;
        result.end_of_buffer = last_byte;
        result.unit_flags    = (last_byte && err_next == ans_pkg::ST_OK) ? flags_next : '0;
        result.status        = last_byte ? err_next : ans_pkg::ST_OK;

        // end of buffer returns to reset
        if (last_byte) begin
            pos_next   = ans_pkg::POS_LEN0;
            acc_next   = '0;
            rem_next   = '0;
            flags_next = '0;
            err_next   = ans_pkg::ST_OK;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= ans_pkg::POS_LEN0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            flags_reg <= '0;
            err_reg   <= ans_pkg::ST_OK;
        end else if (step) begin
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            flags_reg <= flags_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/avcc_to_annexb_nal_scanner_top.sv
// top level: input register, nal core, result register and config register
// result path: the accepted item is registered in the input register, then its result in the result register
// throughput: one item per cycle unless a result waiting on m_tready stalls the input, set by the core state update
// the input register can take one item while a finished result waits to be taken, then holds until it is taken
// reset: synchronous active-low aresetn clears all valid bits, the framing state
// and the codec register (h.264); the byte and result data registers are not reset
`default_nettype none

module avcc_to_annexb_nal_scanner_top #(
    parameter int unsigned NAL_LEN_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data,     // codec_select
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // data_byte[7:0]
    input  wire logic        s_tlast,      // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // out_byte[7:0], unit_flags[11:8], status[13:12]
    output logic             m_tlast       // end_of_buffer
);

    logic                        codec_reg;
    logic                        in_valid_reg;
    logic [ans_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        in_last_reg;
    logic                        out_valid_reg;
    ans_pkg::result_t            out_reg;
    ans_pkg::result_t            core_result;
    logic                        advance;

    // item moves from input register to result register
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // codec register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= ans_pkg::CODEC_H264;
        end else if (cfg_valid && cfg_ready) begin
            codec_reg <= cfg_data[0];
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ans_nal_core #(
        .NAL_LEN_BITS (NAL_LEN_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .codec_select (codec_reg),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .result       (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.end_of_buffer;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.unit_flags, out_reg.out_byte};

`include "avcc_to_annexb_nal_scanner_top_assert.svh"

    // results before the end of a buffer carry no flags and no status
    `ANS_ASSERT_NOW(a_mid_quiet, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[13:8] == 6'd0, "flags or status on a non-final result")
    // a bad status always comes with cleared flags
    `ANS_ASSERT_NOW(a_bad_no_flags, aclk, aresetn, m_tvalid && m_tdata[13:12] != ans_pkg::ST_OK, m_tdata[11:8] == 4'd0, "flags reported with bad status")
    // an empty input register always takes a new item
    `ANS_ASSERT_NOW(a_empty_ready, aclk, aresetn, !in_valid_reg, s_tready, "input stalled while input register empty")
    // a result left untaken stays valid
    `ANS_ASSERT_NEXT(a_out_kept, aclk, aresetn, out_valid_reg && !m_tready, out_valid_reg && $stable(out_reg), "pending result lost or changed")

endmodule

`default_nettype wire

>>> tb/sv/tb_avcc_to_annexb_nal_scanner_top.sv
// self-checking testbench for the avcc to annex b nal scanner: directed and random access units
module tb_avcc_to_annexb_nal_scanner_top;

    localparam int unsigned LEN_BITS    = 32;
    localparam logic [32:0] LEN_LIMIT   = (33'd1 << LEN_BITS) - 33'd1;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // one byte of an access unit as offered to the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } au_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;     // data_byte[7:0]
    logic        s_tlast   = 1'b0;      // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;               // out_byte[7:0], unit_flags[11:8], status[13:12]
    logic        m_tlast;               // end_of_buffer

    avcc_to_annexb_nal_scanner_top #(
        .NAL_LEN_BITS(LEN_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // pending input items and expected converted items
    au_item_t           au_item_q[$];
    ans_pkg::result_t   annexb_q[$];
    logic [7:0]         au_bytes[$];
    int unsigned        items_queued = 0;

    // scanner state mirror
    logic                         codec_reg;
    logic [ans_pkg::POS_W-1:0]    pos_st;
    logic [31:0]                  len_acc;
    logic [31:0]                  pay_left;
    logic [ans_pkg::FLAGS_W-1:0]  flags_acc;
    logic [ans_pkg::STATUS_W-1:0] err_st;

    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    task automatic clear_scan_state();
        pos_st    = ans_pkg::POS_LEN0;
        len_acc   = '0;
        pay_left  = '0;
        flags_acc = '0;
        err_st    = ans_pkg::ST_OK;
    endtask

    // work out the converted item for one accepted byte
    task automatic convert_byte(input logic [7:0] b, input logic last);
        ans_pkg::result_t r;
        logic [5:0]       t265;
        r.out_byte = b;
        if (err_st == ans_pkg::ST_OK) begin
            if (pos_st < ans_pkg::POS_HEADER) begin
                // length byte: replaced by the start code
                r.out_byte = (pos_st == ans_pkg::POS_LEN3) ? 8'h01 : 8'h00;
                len_acc = {len_acc[23:0], b};
                pos_st  = pos_st + 1'b1;
                if (pos_st == ans_pkg::POS_HEADER) begin
                    if (len_acc == 32'd0)
                        err_st = ans_pkg::ST_ZERO_LEN;
                    else if (codec_reg == ans_pkg::CODEC_H265 && len_acc < 32'd2)
                        err_st = ans_pkg::ST_SHORT;
                    else if ({1'b0, len_acc} > LEN_LIMIT)
                        err_st = ans_pkg::ST_TRUNC;
                    else
                        pay_left = len_acc;
                end
            end else begin
                // header byte: classify the unit type
                if (pos_st == ans_pkg::POS_HEADER) begin
                    if (codec_reg == ans_pkg::CODEC_H264) begin
                        case (b[4:0])
                            ans_pkg::H264_SPS: flags_acc[0] = 1'b1;
                            ans_pkg::H264_PPS: flags_acc[1] = 1'b1;
                            ans_pkg::H264_IDR: flags_acc[2] = 1'b1;
                            default: ;
                        endcase
                    end else begin
                        t265 = b[6:1];
                        if (t265 == ans_pkg::H265_VPS)
                            flags_acc[0] = 1'b1;
                        else if (t265 == ans_pkg::H265_SPS)
                            flags_acc[1] = 1'b1;
                        else if (t265 == ans_pkg::H265_PPS)
                            flags_acc[2] = 1'b1;
                        else if (t265 >= ans_pkg::H265_IRAP_LO &&
                                 t265 <= ans_pkg::H265_IRAP_HI)
                            flags_acc[3] = 1'b1;
                    end
                    pos_st = ans_pkg::POS_PAYLOAD;
                end
                pay_left = pay_left - 1'b1;
                if (pay_left == 32'd0) begin
                    pos_st  = ans_pkg::POS_LEN0;
                    len_acc = '0;
                end
            end
            if (last && err_st == ans_pkg::ST_OK && pos_st != ans_pkg::POS_LEN0)
                err_st = ans_pkg::ST_TRUNC;
        end
        r.end_of_buffer = last;
        r.unit_flags    = '0;
        r.status        = ans_pkg::ST_OK;
        if (last) begin
            r.unit_flags = (err_st == ans_pkg::ST_OK) ? flags_acc : '0;
            r.status     = err_st;
            clear_scan_state();
        end
        annexb_q.push_back(r);
    endtask

    // driver: offers queued bytes, mirrors accepted bytes and config writes
    always @(posedge aclk) begin
        au_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            codec_reg = ans_pkg::CODEC_H264;
            clear_scan_state();
            send_wait = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                codec_reg = cfg_data[0];
            if (s_tvalid && s_tready)
                convert_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (au_item_q.size() != 0) begin
                    it = au_item_q.pop_front();
                    s_tdata   <= it.data;
                    s_tlast   <= it.last;
                    s_tvalid  <= 1'b1;
                    send_wait = draw_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes converted items and compares them field by field
    always @(posedge aclk) begin
        ans_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (annexb_q.size() == 0) begin
                    report_mismatch("item with nothing expected, out_byte",
                                    m_tdata[7:0], 0);
                end else begin
                    want = annexb_q.pop_front();
                    if (m_tdata[7:0] !== want.out_byte)
                        report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
                    if (m_tlast !== want.end_of_buffer)
                        report_mismatch("end_of_buffer", m_tlast, want.end_of_buffer);
                    if (m_tdata[11:8] !== want.unit_flags)
                        report_mismatch("unit_flags", m_tdata[11:8], want.unit_flags);
                    if (m_tdata[13:12] !== want.status)
                        report_mismatch("status", m_tdata[13:12], want.status);
                end
                recv_wait = draw_gap(recv_calm);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            m_tready <= (recv_wait == 0);
        end
    end

    // append one length-prefixed unit to the access unit being built
    task automatic add_unit(input int unsigned len, input logic [7:0] hdr);
        for (int i = 3; i >= 0; i--)
            au_bytes.push_back(8'(len >> (8 * i)));
        if (len != 0) begin
            au_bytes.push_back(hdr);
            for (int unsigned i = 1; i < len; i++)
                au_bytes.push_back(8'($urandom));
        end
    endtask

    // move the built access unit to the send queue, marking its final byte
    task automatic queue_buffer();
        au_item_t it;
        for (int i = 0; i < au_bytes.size(); i++) begin
            it.data = au_bytes[i];
            it.last = (i == au_bytes.size() - 1);
            au_item_q.push_back(it);
            items_queued++;
        end
        au_bytes.delete();
    endtask

    // one random access unit: mostly well formed, some broken, some noise
    task automatic gen_buffer(input logic codec);
        int unsigned kind;
        int unsigned units;
        int          bad_at;
        int unsigned len;
        int unsigned r;
        int unsigned cut;
        logic [7:0]  hdr;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 10)) au_bytes.push_back(8'($urandom));
        end else begin
            units  = $urandom_range(1, 4);
            bad_at = (kind == 8) ? int'($urandom_range(0, units - 1)) : -1;
            for (int u = 0; u < units; u++) begin
                r = $urandom_range(0, 39);
                if (r == 0)
                    len = $urandom_range(256, 300);
                else if (r < 6)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(1, 8);
                if (codec == ans_pkg::CODEC_H265 && len < 2)
                    len = 2;
                if (u == bad_at)
                    len = (codec == ans_pkg::CODEC_H265) ? $urandom_range(0, 1) : 0;
                // header with a bias toward the flagged unit types
                hdr = 8'($urandom);
                r   = $urandom_range(0, 4);
                if (codec == ans_pkg::CODEC_H264) begin
                    case (r)
                        0: hdr[4:0] = ans_pkg::H264_SPS;
                        1: hdr[4:0] = ans_pkg::H264_PPS;
                        2: hdr[4:0] = ans_pkg::H264_IDR;
                        default: ;
                    endcase
                end else begin
                    case (r)
                        0: hdr[6:1] = ans_pkg::H265_VPS;
                        1: hdr[6:1] = ans_pkg::H265_SPS;
                        2: hdr[6:1] = ans_pkg::H265_PPS;
                        3: hdr[6:1] = 6'($urandom_range(ans_pkg::H265_IRAP_LO,
                                                        ans_pkg::H265_IRAP_HI));
                        default: ;
                    endcase
                end
                add_unit(len, hdr);
            end
            // truncated buffer: end somewhere inside the byte stream
            if (kind == 7) begin
                cut = $urandom_range(1, au_bytes.size() - 1);
                while (au_bytes.size() > cut)
                    void'(au_bytes.pop_back());
            end
        end
        queue_buffer();
    endtask

    // wait until everything sent has come back, then let the block settle
    task automatic drain();
        do @(negedge aclk);
        while (au_item_q.size() != 0 || s_tvalid || annexb_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_codec(input logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // stimulus
    initial begin
        logic        phase_codec;
        int unsigned start_count;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // h.264 at reset value: sps, pps and idr units, one byte each
        add_unit(1, {3'b011, ans_pkg::H264_SPS});
        add_unit(1, {3'b011, ans_pkg::H264_PPS});
        add_unit(1, {3'b011, ans_pkg::H264_IDR});
        queue_buffer();
        // zero length unit, ends right on its length
        add_unit(0, 8'h00);
        queue_buffer();
        // buffer ends after the header byte, inside the unit
        add_unit(5, {3'b011, ans_pkg::H264_IDR});
        while (au_bytes.size() > 5)
            void'(au_bytes.pop_back());
        queue_buffer();
        drain();

        // h.265 unit one byte long, buffer ends on the length: short wins
        write_codec(ans_pkg::CODEC_H265);
        add_unit(1, 8'h40);
        void'(au_bytes.pop_back());
        queue_buffer();
        drain();

        // random phases, alternating codec
        for (int p = 0; p < 8; p++) begin
            phase_codec = p[0] ? ans_pkg::CODEC_H264 : ans_pkg::CODEC_H265;
            write_codec(phase_codec);
            send_calm   = ($urandom_range(0, 2) == 0);
            recv_calm   = ($urandom_range(0, 2) == 0);
            start_count = items_queued;
            while (items_queued - start_count < 50)
                gen_buffer(phase_codec);
            drain();
        end

        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/ans_pkg.sv
hdl/ans_nal_core.sv
hdl/avcc_to_annexb_nal_scanner_top.sv
tb/sv/tb_avcc_to_annexb_nal_scanner_top.sv
